// File: design/sgirle_pkg.sv
// Package for the SGI RGB run-length scanline decoder.
// Holds the shared types, register indexes, reset values and decoder codes.
// Depends on nothing; every other design file imports it.
`default_nettype none

package sgirle_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 12;
   localparam int PLANE_W  = 2;
   localparam int XPOS_W   = 13;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = 26;
   localparam int PLANES_W = 3;

   // Control register port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_STORAGE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT  = 2'd2;

   // Register reset values.
   localparam logic                MODE_RESET   = 1'b0;
   localparam logic [XPOS_W-1:0]   WIDTH_RESET  = 13'd512;
   localparam logic [PLANES_W-1:0] PLANES_RESET = 3'd3;

   // Storage modes.
   localparam logic MODE_VERBATIM = 1'b0;
   localparam logic MODE_RLE      = 1'b1;

   // A single-plane image replicates grey into green and blue.
   localparam logic [PLANES_W-1:0] GREY_PLANES = 3'd1;

   // Bit of a control byte that selects a literal block over a run.
   localparam int LITERAL_BIT = 7;

   // Result kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EOL   = 1'b1;

   typedef enum logic [1:0] {
      PH_CONTROL = 2'd0,
      PH_LITERAL = 2'd1,
      PH_RUN     = 2'd2,
      PH_ENDED   = 2'd3
   } sgirle_phase_type;

   typedef struct packed {
      logic                storage_mode;
      logic [XPOS_W-1:0]   image_width;
      logic [PLANES_W-1:0] plane_count;
   } sgirle_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic [ROW_W-1:0]   row;
      logic [PLANE_W-1:0] plane;
      logic               row_start;
   } sgirle_req_type;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  pixel_address;
      logic [BYTE_W-1:0]  pixel_value;
      logic [COUNT_W-1:0] run_length;
      logic               grey_copy;
      logic               overrun;
   } sgirle_rsp_type;

endpackage

`default_nettype wire

// File: design/sgirle_chan_if.sv
// Valid/ready channel interfaces for requests and results of the decoder.
// Depends on sgirle_pkg for the field widths.
`default_nettype none

interface sgirle_req_if;
   import sgirle_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic [ROW_W-1:0]   row;
   logic [PLANE_W-1:0] plane;
   logic               row_start;

   modport source (output valid, data_byte, row, plane, row_start, input ready);
   modport sink   (input valid, data_byte, row, plane, row_start, output ready);
endinterface

interface sgirle_rsp_if;
   import sgirle_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [ADDR_W-1:0]  pixel_address;
   logic [BYTE_W-1:0]  pixel_value;
   logic [COUNT_W-1:0] run_length;
   logic               grey_copy;
   logic               overrun;

   modport source (output valid, kind, pixel_address, pixel_value, run_length,
                   grey_copy, overrun, input ready);
   modport sink   (input valid, kind, pixel_address, pixel_value, run_length,
                   grey_copy, overrun, output ready);
endinterface

`default_nettype wire

// File: design/sgirle_in_stage.sv
// Input register of the decoder: holds one request until the decode logic retires it.
// Depends on sgirle_pkg.
`default_nettype none

module sgirle_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  sgirle_pkg::sgirle_req_type in_data,
   output logic                      in_ready,
   output logic                      out_valid,
   output sgirle_pkg::sgirle_req_type out_data,
   input  logic                      out_take
);
   import sgirle_pkg::*;

   logic           valid_ff, valid_in;
   sgirle_req_type data_ff, data_in;

   // The register may refill in the same cycle as its content retires.
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = in_data;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/sgirle_decode.sv
// Scanline decode logic and decoder state (phase, count, position, row, plane).
// Depends on sgirle_pkg.
`default_nettype none

module sgirle_decode #(
   parameter int MAX_WIDTH  = sgirle_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sgirle_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sgirle_pkg::sgirle_cfg_type cfg,
   input  sgirle_pkg::sgirle_req_type item,
   input  logic                      item_take,
   output logic                      has_result,
   output sgirle_pkg::sgirle_rsp_type result
);
   import sgirle_pkg::*;

   localparam int XMAX = (1 << XPOS_W) - 1;
   localparam logic [XPOS_W-1:0] WIDTH_CAP =
      (MAX_WIDTH > XMAX) ? XPOS_W'(XMAX) : XPOS_W'(MAX_WIDTH);
   localparam logic [16:0] HEIGHT_LIM = 17'(MAX_HEIGHT);

   sgirle_phase_type   phase_ff, phase_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [XPOS_W-1:0]  x_ff, x_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;

   // State as seen by this byte: a row start restarts the line first.
   sgirle_phase_type   phase_e;
   logic [COUNT_W-1:0] rem_e;
   logic [XPOS_W-1:0]  x_e;
   logic [ROW_W-1:0]   row_e;
   logic [PLANE_W-1:0] plane_e;

   logic [XPOS_W-1:0]   width_eff;
   logic [COUNT_W-1:0]  count;
   logic [COUNT_W-1:0]  rem_dec;
   logic [COUNT_W-1:0]  wr_len;
   logic                is_write;
   logic                is_eol;
   logic [XPOS_W:0]     x_sum;
   logic                over;
   logic [ADDR_W-3:0]   row_base;
   logic [ADDR_W-3:0]   linear;

   assign phase_e = item.row_start ? PH_CONTROL : phase_ff;
   assign rem_e   = item.row_start ? '0 : rem_ff;
   assign x_e     = item.row_start ? '0 : x_ff;
   assign row_e   = item.row_start ? item.row : row_ff;
   assign plane_e = item.row_start ? item.plane : plane_ff;

   assign width_eff = (cfg.image_width > WIDTH_CAP) ? WIDTH_CAP : cfg.image_width;
   assign count     = item.data_byte[COUNT_W-1:0];
   assign rem_dec   = rem_e - 7'd1;

   assign is_write = (cfg.storage_mode == MODE_VERBATIM) ||
                     (phase_e == PH_LITERAL) || (phase_e == PH_RUN);
   assign is_eol   = (cfg.storage_mode == MODE_RLE) && (phase_e == PH_CONTROL) &&
                     (count == '0);
   assign wr_len   = ((cfg.storage_mode == MODE_RLE) && (phase_e == PH_RUN)) ?
                     rem_e : 7'd1;

   assign x_sum    = (XPOS_W+1)'(x_e) + (XPOS_W+1)'(wr_len);
   assign over     = (x_sum > (XPOS_W+1)'(width_eff)) || (17'(row_e) >= HEIGHT_LIM);

   // Byte address (row * width + x) * 4 + plane, kept to the address width. Only the
   // low bits of the pixel index survive the final shift, so the product is kept to
   // those bits.
   assign row_base = (ADDR_W-2)'(row_e) * (ADDR_W-2)'(width_eff);
   assign linear   = row_base + (ADDR_W-2)'(x_e);

   // Next state.
   always_comb begin
      phase_in = phase_e;
      rem_in   = rem_e;
      x_in     = x_e;
      row_in   = row_e;
      plane_in = plane_e;
      if (cfg.storage_mode == MODE_RLE) begin
         unique case (phase_e)
            PH_CONTROL: begin
               if (count == '0) begin
                  phase_in = PH_ENDED;
               end else begin
                  rem_in   = count;
                  phase_in = item.data_byte[LITERAL_BIT] ? PH_LITERAL : PH_RUN;
               end
            end
            PH_LITERAL: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_CONTROL;
               end
            end
            PH_RUN: begin
               rem_in   = '0;
               phase_in = PH_CONTROL;
            end
            PH_ENDED: begin
               phase_in = PH_ENDED;
            end
            default: begin
               phase_in = PH_CONTROL;
            end
         endcase
      end
      if (is_write && !over) begin
         x_in = x_sum[XPOS_W-1:0];
      end
   end

   // Result.
   always_comb begin
      has_result = 1'b0;
      result     = '0;
      if (is_write) begin
         has_result           = 1'b1;
         result.kind          = KIND_WRITE;
         result.pixel_address = {linear, plane_e};
         result.pixel_value   = item.data_byte;
         result.run_length    = wr_len;
         result.grey_copy     = (cfg.storage_mode == MODE_VERBATIM) &&
                                (cfg.plane_count == GREY_PLANES);
         result.overrun       = over;
      end else if (is_eol) begin
         has_result  = 1'b1;
         result.kind = KIND_EOL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CONTROL;
         rem_ff   <= '0;
         x_ff     <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
      end else if (item_take) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         x_ff     <= x_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
      end
   end

endmodule

`default_nettype wire

// File: design/sgirle_out_stage.sv
// Result register of the decoder: holds one result until the consumer takes it.
// Depends on sgirle_pkg.
`default_nettype none

module sgirle_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  sgirle_pkg::sgirle_rsp_type load_data,
   output logic                      can_load,
   output logic                      out_valid,
   output sgirle_pkg::sgirle_rsp_type out_data,
   input  logic                      out_ready
);
   import sgirle_pkg::*;

   logic           valid_ff, valid_in;
   sgirle_rsp_type data_ff, data_in;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/sgi_rle_scanline_decoder.sv
// Top level of the SGI RGB scanline decoder: control registers, input register,
// decode logic and result register. Depends on sgirle_pkg, sgirle_chan_if and the
// sgirle_in_stage, sgirle_decode and sgirle_out_stage modules.
//
//   Channel    Direction  Handshake              Carries
//   req_chan   in         valid/ready            one scanline byte with row, plane, start
//   rsp_chan   out        valid/ready            one pixel write or end-of-row marker
//   csr_*      in         write enable only      storage mode, image width, plane count
//
// The decoder takes one request per cycle unless the result register is stalled.
// A request is captured in the input register and decoded from there; its result
// (if any) is loaded into the result register and appears on the result channel.
// The rate is set by the single decode stage, whose longest path is the row-times-width
// multiply plus the column add. When the consumer stalls, the result register holds
// its result while the input register still takes one more request; a request that
// produces no result retires even while the output is stalled. Reset is synchronous
// and clears all control state; there is no clearing pass.
`default_nettype none

module sgi_rle_scanline_decoder #(
   parameter int MAX_WIDTH  = sgirle_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sgirle_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   sgirle_req_if.sink                          req_chan,
   sgirle_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [sgirle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sgirle_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sgirle_pkg::*;

   // Control registers. They must be written only while the block is idle; the block itself does not enforce this.
   sgirle_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STORAGE_MODE: cfg_in.storage_mode = csr_wdata[0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[XPOS_W-1:0];
            CSR_PLANE_COUNT:  cfg_in.plane_count  = csr_wdata[PLANES_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.storage_mode <= MODE_RESET;
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.plane_count  <= PLANES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request capture.
   sgirle_req_type req_data;
   sgirle_req_type item;
   logic           item_valid;
   logic           item_take;

   assign req_data.data_byte = req_chan.data_byte;
   assign req_data.row       = req_chan.row;
   assign req_data.plane     = req_chan.plane;
   assign req_data.row_start = req_chan.row_start;

   sgirle_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_data   (req_data),
      .in_ready  (req_chan.ready),
      .out_valid (item_valid),
      .out_data  (item),
      .out_take  (item_take)
   );

   // Decode. The decoder state advances exactly when the held request retires.
   logic           has_result;
   sgirle_rsp_type result;
   logic           out_can_load;
   logic           out_load;

   sgirle_decode #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_take  (item_take),
      .has_result (has_result),
      .result     (result)
   );

   // A request retires when it has no result, or when the result register is free.
   assign item_take = item_valid && (!has_result || out_can_load);
   assign out_load  = item_valid && has_result && out_can_load;

   // Result register.
   sgirle_rsp_type rsp_data;

   sgirle_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (result),
      .can_load  (out_can_load),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.kind          = rsp_data.kind;
   assign rsp_chan.pixel_address = rsp_data.pixel_address;
   assign rsp_chan.pixel_value   = rsp_data.pixel_value;
   assign rsp_chan.run_length    = rsp_data.run_length;
   assign rsp_chan.grey_copy     = rsp_data.grey_copy;
   assign rsp_chan.overrun       = rsp_data.overrun;

   // A request that produces no result never waits on the output side.
   a_no_result_retires: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !has_result) |-> item_take)
      else $error("request without result did not retire");

   // An end-of-row marker carries no write information.
   a_eol_clean: assert property (@(posedge clock) disable iff (reset)
      (out_load && result.kind == KIND_EOL) |->
         (result.pixel_address == '0 && result.pixel_value == '0 &&
          result.run_length == '0 && !result.grey_copy && !result.overrun))
      else $error("end-of-row marker carries write fields");

   // The result register only empties after the consumer has taken its result.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_chan.valid) |-> $past(rsp_chan.ready))
      else $error("result dropped without handshake");

endmodule

`default_nettype wire

// File: test/sgirle_tb_pkg.sv
// Scoreboard for the SGI RGB scanline decoder testbench: predicts pixel writes
// and end-of-row markers from accepted scanline bytes and checks the results.
// Depends on sgirle_pkg for field widths, phase codes and register indexes.
package sgirle_tb_pkg;
   import sgirle_pkg::*;

   localparam int MAX_PRINTED = 40;

   class scanline_scoreboard;
      // Register copies
      logic                mode;
      logic [XPOS_W-1:0]   width;
      logic [PLANES_W-1:0] planes;
      // Decoder state copies
      sgirle_phase_type    phase;
      logic [COUNT_W-1:0]  remaining;
      logic [XPOS_W-1:0]   xpos;
      logic [ROW_W-1:0]    row_q;
      logic [PLANE_W-1:0]  plane_q;

      sgirle_rsp_type pending_writes[$];

      int errors;
      int bytes_noted;
      int bytes_ignored;
      int writes_checked;
      int markers_checked;
      int overruns_checked;
      int grey_checked;

      function new();
         mode      = MODE_RESET;
         width     = WIDTH_RESET;
         planes    = PLANES_RESET;
         phase     = PH_CONTROL;
         remaining = '0;
         xpos      = '0;
         row_q     = '0;
         plane_q   = '0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_STORAGE_MODE: mode = value[0];
            CSR_IMAGE_WIDTH:  width = value[XPOS_W-1:0];
            CSR_PLANE_COUNT:  planes = value[PLANES_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending_count();
         return pending_writes.size();
      endfunction

      // Builds one pixel write at the current column. Writes past the line are
      // flagged and leave the column where it was.
      function sgirle_rsp_type pixel_write(logic [BYTE_W-1:0] value, logic [COUNT_W-1:0] len,
                                           logic grey);
         sgirle_rsp_type w;
         logic [63:0]    span;
         logic [63:0]    reach;
         logic [63:0]    addr;
         logic           over;
         span  = (64'(width) > 64'(MAX_WIDTH_DEFAULT)) ? 64'(MAX_WIDTH_DEFAULT) : 64'(width);
         reach = 64'(xpos) + 64'(len);
         over  = (reach > span) || (64'(row_q) >= 64'(MAX_HEIGHT_DEFAULT));
         addr  = (64'(row_q) * span + 64'(xpos)) * 64'd4 + 64'(plane_q);
         w.kind          = KIND_WRITE;
         w.pixel_address = addr[ADDR_W-1:0];
         w.pixel_value   = value;
         w.run_length    = len;
         w.grey_copy     = grey;
         w.overrun       = over;
         if (!over)
            xpos = xpos + XPOS_W'(len);
         return w;
      endfunction

      // Decodes one accepted byte and queues the result it causes, if any.
      function void note_byte(sgirle_req_type r);
         sgirle_rsp_type marker;
         bytes_noted++;
         if (r.row_start) begin
            row_q     = r.row;
            plane_q   = r.plane;
            xpos      = '0;
            phase     = PH_CONTROL;
            remaining = '0;
         end
         if (mode == MODE_VERBATIM) begin
            pending_writes.push_back(pixel_write(r.data_byte, COUNT_W'(1), planes == GREY_PLANES));
         end else begin
            case (phase)
               PH_CONTROL: begin
                  if (r.data_byte[COUNT_W-1:0] == '0) begin
                     phase  = PH_ENDED;
                     marker = '0;
                     marker.kind = KIND_EOL;
                     pending_writes.push_back(marker);
                  end else begin
                     remaining = r.data_byte[COUNT_W-1:0];
                     phase = r.data_byte[LITERAL_BIT] ? PH_LITERAL : PH_RUN;
                  end
               end
               PH_LITERAL: begin
                  pending_writes.push_back(pixel_write(r.data_byte, COUNT_W'(1), 1'b0));
                  remaining = remaining - COUNT_W'(1);
                  if (remaining == '0)
                     phase = PH_CONTROL;
               end
               PH_RUN: begin
                  pending_writes.push_back(pixel_write(r.data_byte, remaining, 1'b0));
                  remaining = '0;
                  phase     = PH_CONTROL;
               end
               default: bytes_ignored++;
            endcase
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("MISMATCH: %s", msg);
      endtask

      task compare_field(string name, int index, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      index, name, got, want));
      endtask

      task check_write(sgirle_rsp_type got);
         sgirle_rsp_type want;
         int             index;
         index = writes_checked + markers_checked;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", index));
         end else begin
            want = pending_writes.pop_front();
            compare_field("kind", index, 32'(got.kind), 32'(want.kind));
            compare_field("pixel_address", index, 32'(got.pixel_address),
                          32'(want.pixel_address));
            compare_field("pixel_value", index, 32'(got.pixel_value), 32'(want.pixel_value));
            compare_field("run_length", index, 32'(got.run_length), 32'(want.run_length));
            compare_field("grey_copy", index, 32'(got.grey_copy), 32'(want.grey_copy));
            compare_field("overrun", index, 32'(got.overrun), 32'(want.overrun));
            if (want.kind == KIND_EOL) begin
               markers_checked++;
            end else begin
               writes_checked++;
               if (want.overrun)
                  overruns_checked++;
               if (want.grey_copy)
                  grey_checked++;
            end
         end
      endtask

      task report_leftover();
         if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_writes.size()));
      endtask
   endclass

endpackage

// File: test/tb_top.sv
// Top-level testbench for sgi_rle_scanline_decoder: drives scanline bytes and
// register writes, stalls the result side and checks every result in order.
// Depends on sgirle_pkg, the channel interfaces and sgirle_tb_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sgirle_pkg::*;
   import sgirle_tb_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 6;
   // Extra settle time covers control bytes that retire without a result while
   // the last write is still in flight.
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int RANDOM_BYTES  = 700;
   localparam int CYCLE_LIMIT   = 300000;

   localparam logic [BYTE_W-1:0] END_OF_ROW = 8'h00;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sgirle_req_if req_if ();
   sgirle_rsp_if rsp_if ();

   scanline_scoreboard sb;

   // Handshake between the stimulus and the result sink: when set, the sink
   // holds ready low for HOLD_CYCLES so the block backs up into its input.
   logic hold_request = 1'b0;
   int   burst_left = 0;
   int   cycle_count = 0;
   int   settings_applied = 0;

   sgi_rle_scanline_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Run limit. Far above the slowest legal run: every byte waiting out a
   // sender gap, a mostly stalled receiver and the long hold-off.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending_count());
         $display("Some tests failed");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge, before the block updates.
   // An accepted request feeds the predictor; an accepted result is checked.
   always @(posedge clock) begin : observe
      sgirle_req_type req_seen;
      sgirle_rsp_type rsp_seen;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_seen.data_byte = req_if.data_byte;
            req_seen.row       = req_if.row;
            req_seen.plane     = req_if.plane;
            req_seen.row_start = req_if.row_start;
            sb.note_byte(req_seen);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen.kind          = rsp_if.kind;
            rsp_seen.pixel_address = rsp_if.pixel_address;
            rsp_seen.pixel_value   = rsp_if.pixel_value;
            rsp_seen.run_length    = rsp_if.run_length;
            rsp_seen.grey_copy     = rsp_if.grey_copy;
            rsp_seen.overrun       = rsp_if.overrun;
            sb.check_write(rsp_seen);
         end
      end
   end

   // Result sink. It switches at random between stall styles:
   // always ready, coin flip, a fixed one-in-three stall and mostly stalled.
   initial begin : result_sink
      int style_left;
      int style;
      style_left = 0;
      style = 0;
      rsp_if.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(16, 80);
         end
         style_left--;
         case (style)
            0: rsp_if.ready = 1'b1;
            1: rsp_if.ready = 1'($urandom_range(0, 1));
            2: rsp_if.ready = (style_left % 3) != 0;
            default: rsp_if.ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [BYTE_W-1:0] literal_ctrl(int count);
      return {1'b1, COUNT_W'(count)};
   endfunction

   function automatic logic [BYTE_W-1:0] run_ctrl(int count);
      return {1'b0, COUNT_W'(count)};
   endfunction

   // Rows lean toward the first and last scanline so the address extremes show up.
   function automatic logic [ROW_W-1:0] pick_row();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return ROW_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(MAX_WIDTH_DEFAULT);
         3: return '1;
         4: return CSR_DATA_W'($urandom_range(0, 8191));
         5, 6: return CSR_DATA_W'($urandom_range(65, 600));
         default: return CSR_DATA_W'($urandom_range(2, 64));
      endcase
   endfunction

   // Register writes happen only with the block idle, so the predictor copy
   // can be updated at the same moment.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      sb.set_register(index, value);
      settings_applied++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Offers one request and returns at the falling edge after it was taken.
   // The sender works in bursts; between bursts valid drops low, and some bursts
   // follow straight on so long unbroken stretches occur too.
   task automatic drive_request(input logic [BYTE_W-1:0] data, input logic [ROW_W-1:0] row,
                                input logic [PLANE_W-1:0] plane, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.data_byte = data;
      req_if.row       = row;
      req_if.plane     = plane;
      req_if.row_start = start;
      req_if.valid     = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Row and plane are randomized on every byte; the block must ignore them
   // unless row_start is set.
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
      drive_request(data, pick_row(), PLANE_W'($urandom_range(0, 3)), start);
   endtask

   // Drops valid and waits until every expected result has been checked, then
   // lets the pipeline empty of requests that give no result.
   task automatic wait_idle();
      req_if.valid = 1'b0;
      burst_left = 0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A run-length scanline: a handful of literal blocks and runs, usually
   // closed by an end-of-row marker with a few ignored bytes behind it.
   // Without a start flag the packets continue whatever line was open.
   task automatic send_rle_row(input logic with_start);
      int   packets;
      int   count;
      logic first;
      first = with_start;
      packets = $urandom_range(1, 6);
      repeat (packets) begin
         if ($urandom_range(0, 1) == 0) begin
            count = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
            send_byte(literal_ctrl(count), first);
            first = 1'b0;
            repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
         end else begin
            count = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
            send_byte(run_ctrl(count), first);
            first = 1'b0;
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         // The marker is any control byte with a zero count, high bit or not.
         send_byte(($urandom_range(0, 1) == 0) ? END_OF_ROW : literal_ctrl(0), first);
         repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic send_verbatim_row();
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(0, 12)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // Unstructured bytes with stray row starts: broken packets and lines.
   task automatic send_noise(input int count);
      repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   // Short directed part: grey replication and overrun in verbatim mode, both
   // packet kinds at their extremes, both forms of the end-of-row marker and
   // the bytes ignored after it, a zero width, and mode changes in mid-row.
   task automatic run_directed();
      write_register(CSR_PLANE_COUNT, CSR_DATA_W'(GREY_PLANES));
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      drive_request(8'hFF, '1, '1, 1'b1);
      drive_request(8'h00, '0, '0, 1'b0);
      drive_request(8'hA5, 12'h5A5, 2'd1, 1'b0);
      drive_request(8'h5A, 12'hA5A, 2'd2, 1'b0);   // fourth pixel of three

      // Width above the maximum acts as the maximum; last row, last plane.
      wait_idle();
      write_register(CSR_STORAGE_MODE, CSR_DATA_W'(MODE_RLE));
      write_register(CSR_IMAGE_WIDTH, '1);
      write_register(CSR_PLANE_COUNT, CSR_DATA_W'(4));
      drive_request(literal_ctrl(1), '1, '1, 1'b1);
      drive_request(8'hFF, '0, '0, 1'b0);
      drive_request(run_ctrl(127), '0, '0, 1'b0);
      drive_request(8'h00, '1, '1, 1'b0);
      drive_request(literal_ctrl(2), '0, '0, 1'b0);
      drive_request(8'h81, '0, '0, 1'b0);
      drive_request(8'h7E, '0, '0, 1'b0);
      drive_request(END_OF_ROW, '0, '0, 1'b0);
      drive_request(8'h55, '1, '1, 1'b0);          // dropped after the marker
      drive_request(literal_ctrl(0), '0, '0, 1'b1);

      // Zero width: every write overruns. The literal block is left open.
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_PLANE_COUNT, '0);
      drive_request(run_ctrl(1), 12'd7, 2'd2, 1'b1);
      drive_request(8'h12, '0, '0, 1'b0);
      drive_request(literal_ctrl(2), '0, '0, 1'b0);
      drive_request(8'h34, '0, '0, 1'b0);

      // Verbatim bytes in the same line ignore the open block.
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(1));
      write_register(CSR_PLANE_COUNT, CSR_DATA_W'(7));
      write_register(CSR_STORAGE_MODE, CSR_DATA_W'(MODE_VERBATIM));
      drive_request(8'h77, '0, '0, 1'b0);
      drive_request(8'h88, '0, '0, 1'b0);

      // Back to run-length: the open literal block takes the next byte.
      wait_idle();
      write_register(CSR_STORAGE_MODE, CSR_DATA_W'(MODE_RLE));
      drive_request(8'h99, '0, '0, 1'b0);
      drive_request(END_OF_ROW, '0, '0, 1'b0);
   endtask

   // The sink holds off for a long stretch while a literal block streams in,
   // so the result register and the input register fill and the input
   // stalls. The sender then waits until every result has come back.
   task automatic run_backpressure();
      wait_idle();
      write_register(CSR_STORAGE_MODE, CSR_DATA_W'(MODE_RLE));
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(MAX_WIDTH_DEFAULT));
      hold_request = 1'b1;
      send_byte(literal_ctrl(24), 1'b1);
      repeat (24) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      wait_idle();
   endtask

   // One random phase: new settings on an idle block, then a few lines.
   // Mode is written every time; width and plane count only sometimes, so
   // settings carry over and lines may continue across phases.
   task automatic run_random_phase();
      int lines;
      wait_idle();
      write_register(CSR_STORAGE_MODE,
                     CSR_DATA_W'(($urandom_range(0, 3) != 0) ? MODE_RLE : MODE_VERBATIM));
      if ($urandom_range(0, 1) == 0)
         write_register(CSR_IMAGE_WIDTH, pick_width());
      if ($urandom_range(0, 2) == 0)
         write_register(CSR_PLANE_COUNT,
                        ($urandom_range(0, 1) == 0) ? CSR_DATA_W'(GREY_PLANES)
                                                    : CSR_DATA_W'($urandom_range(0, 7)));
      lines = $urandom_range(2, 5);
      repeat (lines) begin
         if ($urandom_range(0, 9) == 0)
            send_noise($urandom_range(1, 8));
         else if (sb.mode == MODE_RLE)
            send_rle_row($urandom_range(0, 7) != 0);
         else
            send_verbatim_row();
      end
   endtask

   initial begin : stimulus
      int target;
      sb = new();
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.row       = '0;
      req_if.plane     = '0;
      req_if.row_start = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      run_directed();
      // Bytes dropped after an end-of-row marker do not count as stimulus.
      target = sb.bytes_noted - sb.bytes_ignored + RANDOM_BYTES;
      run_backpressure();
      while (sb.bytes_noted - sb.bytes_ignored < target)
         run_random_phase();

      wait_idle();
      sb.report_leftover();
      $display("Covered %0d bytes (%0d dropped after end of row): %0d pixel writes, %0d overruns,",
               sb.bytes_noted, sb.bytes_ignored, sb.writes_checked, sb.overruns_checked);
      $display("%0d grey writes and %0d end-of-row markers, over %0d register writes.",
               sb.grey_checked, sb.markers_checked, settings_applied);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
